// ===== hw/rtl/wesf_pkg.sv =====
// ---------------------------------------------------------------------------
// wesf_pkg
// Shared widths, register indexes, reset values and the control/status
// structs of the weight stability filter.
// ---------------------------------------------------------------------------
package wesf_pkg;

    // Fixed-point format of the weight
    localparam int FRAC_BITS   = 16;
    localparam int SCALE_SHIFT = FRAC_BITS + 8;
    localparam int ALPHA_BITS  = 16;

    // Field and register widths
    localparam int W_RAW      = 24;
    localparam int W_WEIGHT   = 22;
    localparam int W_GAIN     = 24;
    localparam int W_ALPHA    = 17;
    localparam int W_TOL      = 22;
    localparam int W_NEED     = 4;
    localparam int W_COUNT    = 32;
    localparam int W_CFG_IDX  = 2;
    localparam int W_CFG_DATA = 24;

    // Shared multiplier: signed operands, full-width product
    localparam int MUL_W  = W_RAW + 1;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [W_WEIGHT-1:0] WEIGHT_MAX = {W_WEIGHT{1'b1}};
    localparam logic [W_ALPHA-1:0]  ALPHA_ONE  = W_ALPHA'(1) << ALPHA_BITS;
    localparam logic [PROD_W-1:0]   AVG_ROUND  = PROD_W'(1) << (ALPHA_BITS - 1);

    // Input word actions
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TARE   = 1'b1;

    // Configuration register indexes
    localparam logic [W_CFG_IDX-1:0] CFG_SCALE_GAIN       = 2'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_SMOOTHING_ALPHA  = 2'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_STABLE_TOLERANCE = 2'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_STABLE_NEEDED    = 2'd3;

    // Configuration reset values
    localparam logic [W_GAIN-1:0]  RST_SCALE_GAIN       = 24'd3698255;
    localparam logic [W_ALPHA-1:0] RST_SMOOTHING_ALPHA  = 17'd22938;
    localparam logic [W_TOL-1:0]   RST_STABLE_TOLERANCE = 22'd131;
    localparam logic [W_NEED-1:0]  RST_STABLE_NEEDED    = 4'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;    // take an input word, apply a tare at once
        logic mul_scale;  // product of offset-corrected sample and gain
        logic check;      // clamp, count, stability run, first-sample load
        logic mul_avg;    // product of alpha and sample-to-average step
        logic avg;        // fold the product into the smoothed weight
        logic load_out;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_tare;    // captured word is a tare command
        logic first;      // next sample loads the average directly
        logic out_free;   // output register can take a word this cycle
    } t_dp_status;

endpackage

// ===== hw/rtl/wesf_ctrl.sv =====
// ---------------------------------------------------------------------------
// wesf_ctrl
// Sequencer of the weight stability filter: steps one sample word through scale,
// check and, but for a first sample, average; the result goes to the output register.
// ---------------------------------------------------------------------------
module wesf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  wesf_pkg::t_dp_status i_status,
    output wesf_pkg::t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MUL2  = 3'd3;
    localparam logic [2:0] S_AVG   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Take a new word only while idle
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_MUL1;
                end
            end
            S_MUL1: begin
                if (i_status.is_tare) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.mul_scale = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_status.first ? S_OUT : S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_avg = 1'b1;
                n_state       = S_AVG;
            end
            S_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/wesf_datapath.sv =====
// ---------------------------------------------------------------------------
// wesf_datapath
// Configuration registers, filter state, one shared signed multiplier and
// the output register of the weight stability filter.
// ---------------------------------------------------------------------------
module wesf_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [wesf_pkg::W_CFG_IDX-1:0]        i_cfg_index,
    input  logic [wesf_pkg::W_CFG_DATA-1:0]       i_cfg_data,
    // input word
    input  logic                                  i_action,
    input  logic signed [wesf_pkg::W_RAW-1:0]     i_raw_sample,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [wesf_pkg::W_WEIGHT-1:0]         o_smoothed_weight,
    output logic                                  o_stable,
    output logic [wesf_pkg::W_COUNT-1:0]          o_sample_count,
    // control
    input  wesf_pkg::t_dp_cmd                     i_cmd,
    output wesf_pkg::t_dp_status                  o_status
);

    // Configuration
    logic [wesf_pkg::W_GAIN-1:0]   r_scale_gain;
    logic [wesf_pkg::W_ALPHA-1:0]  r_alpha;
    logic [wesf_pkg::W_TOL-1:0]    r_tolerance;
    logic [wesf_pkg::W_NEED-1:0]   r_needed;

    // Filter state
    logic signed [wesf_pkg::W_RAW-1:0] r_offset;
    logic [wesf_pkg::W_WEIGHT-1:0]     r_filt;
    logic                              r_first;
    logic [wesf_pkg::W_NEED-1:0]       r_run;
    logic [wesf_pkg::W_COUNT-1:0]      r_count;

    // Working registers
    logic                              r_is_tare;
    logic signed [wesf_pkg::MUL_W-1:0] r_diff;
    logic signed [wesf_pkg::PROD_W-1:0] r_prod;
    logic [wesf_pkg::W_WEIGHT-1:0]     r_x;

    // Output register
    logic                              r_out_valid;
    logic [wesf_pkg::W_WEIGHT-1:0]     r_out_weight;
    logic                              r_out_stable;
    logic [wesf_pkg::W_COUNT-1:0]      r_out_count;

    logic signed [wesf_pkg::MUL_W-1:0] mul_a;
    logic signed [wesf_pkg::MUL_W-1:0] mul_b;
    logic [wesf_pkg::W_ALPHA-1:0]      alpha_eff;
    logic                              diff_pos;
    logic [wesf_pkg::PROD_W-1:0]       scaled;
    logic [wesf_pkg::W_WEIGHT-1:0]     n_x;
    logic [wesf_pkg::W_WEIGHT-1:0]     step_abs;
    logic [wesf_pkg::PROD_W-1:0]       avg_sum;
    logic [wesf_pkg::W_WEIGHT-1:0]     n_filt;
    logic [wesf_pkg::W_NEED-1:0]       n_run;
    logic                              in_tare;

    // Decode the input action
    assign in_tare = (i_action == wesf_pkg::ACT_TARE);

    // Clamp alpha to one
    assign alpha_eff = r_alpha[wesf_pkg::ALPHA_BITS] ? wesf_pkg::ALPHA_ONE : r_alpha;

    // Select multiplier operands: gain step or average step
    always_comb begin
        if (i_cmd.mul_avg) begin
            mul_a = {{(wesf_pkg::MUL_W - wesf_pkg::W_WEIGHT){1'b0}}, r_x}
                  - {{(wesf_pkg::MUL_W - wesf_pkg::W_WEIGHT){1'b0}}, r_filt};
            mul_b = {{(wesf_pkg::MUL_W - wesf_pkg::W_ALPHA){1'b0}}, alpha_eff};
        end else begin
            mul_a = r_diff;
            mul_b = {{(wesf_pkg::MUL_W - wesf_pkg::W_GAIN){1'b0}}, r_scale_gain};
        end
    end

    // Shift and clamp the scaled sample
    assign diff_pos = !r_diff[wesf_pkg::MUL_W-1] && (r_diff != '0);
    assign scaled   = unsigned'(r_prod) >> wesf_pkg::SCALE_SHIFT;
    always_comb begin
        if (!diff_pos) begin
            n_x = '0;
        end else if (|scaled[wesf_pkg::PROD_W-1:wesf_pkg::W_WEIGHT]) begin
            n_x = wesf_pkg::WEIGHT_MAX;
        end else begin
            n_x = scaled[wesf_pkg::W_WEIGHT-1:0];
        end
    end

    // Update the stability run against the previous average
    assign step_abs = (n_x >= r_filt) ? (n_x - r_filt) : (r_filt - n_x);
    always_comb begin
        if (step_abs <= r_tolerance) begin
            n_run = (r_run < r_needed) ? r_run + 1'b1 : r_run;
        end else begin
            n_run = '0;
        end
    end

    // Average: avg*one + alpha*(x - avg), rounded half up
    assign avg_sum = {{(wesf_pkg::PROD_W - wesf_pkg::W_WEIGHT - wesf_pkg::ALPHA_BITS){1'b0}},
                      r_filt, {wesf_pkg::ALPHA_BITS{1'b0}}}
                   + unsigned'(r_prod) + wesf_pkg::AVG_ROUND;
    assign n_filt  = avg_sum[wesf_pkg::ALPHA_BITS +: wesf_pkg::W_WEIGHT];

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_gain <= wesf_pkg::RST_SCALE_GAIN;
            r_alpha      <= wesf_pkg::RST_SMOOTHING_ALPHA;
            r_tolerance  <= wesf_pkg::RST_STABLE_TOLERANCE;
            r_needed     <= wesf_pkg::RST_STABLE_NEEDED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wesf_pkg::CFG_SCALE_GAIN:
                    r_scale_gain <= i_cfg_data[wesf_pkg::W_GAIN-1:0];
                wesf_pkg::CFG_SMOOTHING_ALPHA:
                    r_alpha <= i_cfg_data[wesf_pkg::W_ALPHA-1:0];
                wesf_pkg::CFG_STABLE_TOLERANCE:
                    r_tolerance <= i_cfg_data[wesf_pkg::W_TOL-1:0];
                wesf_pkg::CFG_STABLE_NEEDED:
                    r_needed <= i_cfg_data[wesf_pkg::W_NEED-1:0];
                default: begin
                end
            endcase
        end
    end

    // Filter state: tare on capture; count, first-sample load and run on check; average on avg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_filt   <= '0;
            r_first  <= 1'b1;
            r_run    <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.capture && in_tare) begin
                r_offset <= i_raw_sample;
                r_filt   <= '0;
                r_first  <= 1'b1;
                r_run    <= '0;
            end
            if (i_cmd.check) begin
                r_count <= r_count + 1'b1;
                if (r_first) begin
                    r_filt  <= n_x;
                    r_first <= 1'b0;
                    r_run   <= '0;
                end else begin
                    r_run <= n_run;
                end
            end
            if (i_cmd.avg) begin
                r_filt <= n_filt;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_is_tare <= in_tare;
            r_diff    <= {i_raw_sample[wesf_pkg::W_RAW-1], i_raw_sample}
                       - {r_offset[wesf_pkg::W_RAW-1], r_offset};
        end
        if (i_cmd.mul_scale || i_cmd.mul_avg) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.check) begin
            r_x <= n_x;
        end
    end

    // Output register: load a word, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_weight <= r_filt;
            r_out_stable <= (r_run >= r_needed);
            r_out_count  <= r_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_smoothed_weight = r_out_weight;
    assign o_stable          = r_out_stable;
    assign o_sample_count    = r_out_count;

    assign o_status.is_tare  = r_is_tare;
    assign o_status.first    = r_first;
    assign o_status.out_free = !r_out_valid || !i_stall;

endmodule

// ===== hw/rtl/weight_ema_stability_filter.sv =====
// ---------------------------------------------------------------------------
// weight_ema_stability_filter
// Load-cell conditioning: tare offset, gain scaling with clamp, moving
// average with a saturating stability run and a sample counter.
// ---------------------------------------------------------------------------
// Sequence: a sample word passes capture, the scale product, check, the average
//   product, average and output load (a first sample after reset or tare skips
//   the average, a tare word goes from capture straight to output load); one word
//   is in work at a time, paced by a sample's two passes through the single shared
//   multiplier, and the output load waits while a full output register is stalled.
//   The next word is taken while the previous result still waits in the output
//   register. Reset: synchronous, active low; loads the default configuration
//   and clears the offset, average, stability run and sample count.
module weight_ema_stability_filter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic [wesf_pkg::W_CFG_IDX-1:0]        i_cfg_index,
    input  logic [wesf_pkg::W_CFG_DATA-1:0]       i_cfg_data,
    // input channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic                                  i_action,
    input  logic signed [wesf_pkg::W_RAW-1:0]     i_raw_sample,
    // output channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [wesf_pkg::W_WEIGHT-1:0]         o_smoothed_weight,
    output logic                                  o_stable,
    output logic [wesf_pkg::W_COUNT-1:0]          o_sample_count
);

    wesf_pkg::t_dp_cmd    cmd;
    wesf_pkg::t_dp_status status;

    // Sequencer
    wesf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Arithmetic and state
    wesf_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_raw_sample      (i_raw_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_smoothed_weight (o_smoothed_weight),
        .o_stable          (o_stable),
        .o_sample_count    (o_sample_count),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule

// ===== test/weight_ema_stability_filter_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weight_ema_stability_filter_tb
// Drives sample and tare words through the weight filter under random
// sender gaps and receiver stalls. A scoreboard class predicts the smoothed
// weight, the stable flag and the sample count of every word and checks each
// result word in order. Five register settings are used, the extremes among
// them.
// ---------------------------------------------------------------------------
module weight_ema_stability_filter_tb;
    import wesf_pkg::*;

    localparam int   SETTLE     = 10;   // idle cycles before a register write
    localparam int   LONG_HOLD  = 80;   // receiver hold-off, cycles
    localparam int   TAIL       = 20;

    typedef struct {
        logic [W_WEIGHT-1:0] weight;
        logic                stable;
        logic [W_COUNT-1:0]  count;
    } t_reading;

    // Predict the filter and check result words against the predictions
    class wesf_scoreboard;
        logic [W_GAIN-1:0]       gain;
        logic [W_ALPHA-1:0]      alpha;
        logic [W_TOL-1:0]        tol;
        logic [W_NEED-1:0]       need;
        logic signed [W_RAW-1:0] offset;
        logic [W_WEIGHT-1:0]     avg;
        bit                      first;
        logic [W_NEED-1:0]       run;
        logic [W_COUNT-1:0]      count;
        t_reading                expected_readings[$];
        int unsigned             errors;

        function new();
            gain   = RST_SCALE_GAIN;
            alpha  = RST_SMOOTHING_ALPHA;
            tol    = RST_STABLE_TOLERANCE;
            need   = RST_STABLE_NEEDED;
            offset = '0;
            avg    = '0;
            first  = 1'b1;
            run    = '0;
            count  = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [W_CFG_IDX-1:0] idx, logic [W_CFG_DATA-1:0] data);
            case (idx)
                CFG_SCALE_GAIN:       gain  = data[W_GAIN-1:0];
                CFG_SMOOTHING_ALPHA:  alpha = data[W_ALPHA-1:0];
                CFG_STABLE_TOLERANCE: tol   = data[W_TOL-1:0];
                CFG_STABLE_NEEDED:    need  = data[W_NEED-1:0];
                default: ;
            endcase
        endfunction

        // Offset-correct, scale by the gain, clamp to zero and full scale
        function logic [W_WEIGHT-1:0] scale_to_weight(logic signed [W_RAW-1:0] raw);
            int                diff;
            longint unsigned   prod;
            diff = int'(raw) - int'(offset);
            if (diff <= 0) return '0;
            prod = longint'(diff) * longint'(gain);
            prod = prod >> SCALE_SHIFT;
            if (prod > longint'(WEIGHT_MAX)) return WEIGHT_MAX;
            return W_WEIGHT'(prod);
        endfunction

        // Advance the filter by one accepted word and queue its reading
        function void note_word(logic act, logic signed [W_RAW-1:0] raw);
            logic [W_WEIGHT-1:0] x;
            logic [W_WEIGHT-1:0] step;
            longint unsigned     a;
            longint unsigned     sum;
            t_reading            rd;
            if (act == ACT_TARE) begin
                offset = raw;
                avg    = '0;
                first  = 1'b1;
                run    = '0;
            end else begin
                x     = scale_to_weight(raw);
                count = count + 1;
                if (first) begin
                    avg   = x;
                    first = 1'b0;
                    run   = '0;
                end else begin
                    step = (x >= avg) ? x - avg : avg - x;
                    if (step <= tol) begin
                        if (run < need) run = run + 1;
                    end else begin
                        run = '0;
                    end
                    a   = (alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha);
                    sum = a * x + (longint'(ALPHA_ONE) - a) * avg
                        + (longint'(ALPHA_ONE) >> 1);
                    avg = W_WEIGHT'(sum >> ALPHA_BITS);
                end
            end
            rd.weight = avg;
            rd.stable = (run >= need);
            rd.count  = count;
            expected_readings.push_back(rd);
        endfunction

        function void check_word(logic [W_WEIGHT-1:0] w, logic s, logic [W_COUNT-1:0] c);
            t_reading rd;
            if (expected_readings.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result word weight=%0d stable=%0b count=%0d",
                             $realtime, w, s, c);
                return;
            end
            rd = expected_readings.pop_front();
            if (w !== rd.weight || s !== rd.stable || c !== rd.count) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch weight exp=%0d act=%0d stable exp=%0b act=%0b count exp=%0d act=%0d",
                             $realtime, rd.weight, w, rd.stable, s, rd.count, c);
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [W_CFG_IDX-1:0]    i_cfg_index;
    logic [W_CFG_DATA-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_action;
    logic signed [W_RAW-1:0] i_raw_sample;
    logic                    o_valid;
    logic                    i_stall;
    logic [W_WEIGHT-1:0]     o_smoothed_weight;
    logic                    o_stable;
    logic [W_COUNT-1:0]      o_sample_count;

    wesf_scoreboard filter_sb = new();
    bit             long_hold_req = 1'b0;
    int             burst_left = 0;

    weight_ema_stability_filter u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_action          (i_action),
        .i_raw_sample      (i_raw_sample),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_smoothed_weight (o_smoothed_weight),
        .o_stable          (o_stable),
        .o_sample_count    (o_sample_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up after a generous fixed time
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            filter_sb.check_word(o_smoothed_weight, o_stable, o_sample_count);
    end

    // Stall the result side in stretches; hold off for long when asked
    initial begin
        int unsigned span;
        int unsigned pct;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            span = $urandom_range(4, 40);
            pct  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
            repeat (span) begin
                i_stall <= ($urandom_range(0, 99) < pct);
                @(posedge i_clk);
            end
        end
    end

    // Offer one word and hold it until it is taken
    task automatic send_word(input logic act, input logic signed [W_RAW-1:0] raw);
        i_valid      <= 1'b1;
        i_action     <= act;
        i_raw_sample <= raw;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        filter_sb.note_word(act, raw);
    endtask

    // Drop valid and wait until every reading has come back
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (filter_sb.pending() != 0) @(posedge i_clk);
    endtask

    // Sender pacing: random bursts with random gaps between them
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 12);
        gap = $urandom_range(0, 15);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx,
                             input logic [W_CFG_DATA-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        filter_sb.set_reg(idx, data);
    endtask

    // Write all four registers while the block is idle
    task automatic configure(input logic [W_GAIN-1:0] gain, input logic [W_ALPHA-1:0] alpha,
                             input logic [W_TOL-1:0] tol, input logic [W_NEED-1:0] need);
        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_SCALE_GAIN, W_CFG_DATA'(gain));
        write_reg(CFG_SMOOTHING_ALPHA, W_CFG_DATA'(alpha));
        write_reg(CFG_STABLE_TOLERANCE, W_CFG_DATA'(tol));
        write_reg(CFG_STABLE_NEEDED, W_CFG_DATA'(need));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly plateaus of nearby samples, with tares, jumps and wild samples
    task automatic run_random(input int n, input bit paced);
        int base;
        int amp;
        int noise;
        int r;
        base = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
        amp  = (1 << $urandom_range(0, 12)) - 1;
        repeat (n) begin
            if (paced) pace_sender();
            if ($urandom_range(0, 49) == 0) hold_until_drained();
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_word(ACT_TARE, ($urandom_range(0, 1) == 0) ? W_RAW'($urandom)
                                                               : W_RAW'(base - amp));
            end else if (r < 12) begin
                send_word(ACT_SAMPLE, W_RAW'($urandom));
            end else begin
                if (r < 20) begin
                    base = int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
                    amp  = (1 << $urandom_range(0, 12)) - 1;
                end
                noise = int'($urandom_range(0, 2 * amp)) - amp;
                send_word(ACT_SAMPLE, W_RAW'(base + noise));
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= CFG_SCALE_GAIN;
        i_cfg_data   <= '0;
        i_valid      <= 1'b0;
        i_action     <= ACT_SAMPLE;
        i_raw_sample <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words under the reset settings: first-sample load, the run
        // up to stable and its saturation, full-scale and negative samples,
        // tares at both ends of the range, samples at and below the offset
        repeat (5) send_word(ACT_SAMPLE, 24'sd0);
        send_word(ACT_SAMPLE, 24'sh7FFFFF);
        send_word(ACT_SAMPLE, 24'sh800000);
        send_word(ACT_TARE, 24'sh800000);
        send_word(ACT_SAMPLE, 24'sh7FFFFF);
        send_word(ACT_SAMPLE, 24'sh800000);
        send_word(ACT_SAMPLE, 24'sh800001);
        send_word(ACT_TARE, 24'sh7FFFFF);
        send_word(ACT_SAMPLE, 24'sh7FFFFF);
        send_word(ACT_SAMPLE, 24'sd0);
        send_word(ACT_TARE, 24'sd0);
        repeat (4) send_word(ACT_SAMPLE, 24'sd1000);
        send_word(ACT_SAMPLE, 24'sd1200);
        send_word(ACT_SAMPLE, 24'sd500000);
        send_word(ACT_TARE, 24'sd12345);
        send_word(ACT_SAMPLE, 24'sd400000);

        // Reset values written back; long receiver hold while words keep coming
        configure(RST_SCALE_GAIN, RST_SMOOTHING_ALPHA, RST_STABLE_TOLERANCE,
                  RST_STABLE_NEEDED);
        long_hold_req = 1'b1;
        run_random(20, 1'b0);
        run_random(70, 1'b1);

        // Full gain, full alpha, zero tolerance, longest run
        configure({W_GAIN{1'b1}}, ALPHA_ONE, '0, {W_NEED{1'b1}});
        run_random(80, 1'b1);

        // Zero gain, zero alpha, widest tolerance, a run of one
        configure('0, '0, W_TOL'(WEIGHT_MAX), W_NEED'(1));
        run_random(50, 1'b1);

        // Alpha above one saturates; a zero run length reads stable at once
        configure(W_GAIN'($urandom), {W_ALPHA{1'b1}}, W_TOL'($urandom_range(0, 4000)), '0);
        long_hold_req = 1'b1;
        run_random(20, 1'b0);
        run_random(50, 1'b1);

        // Random mid-range setting
        configure(W_GAIN'($urandom), W_ALPHA'($urandom_range(0, 65536)),
                  W_TOL'($urandom_range(0, 2000)), W_NEED'($urandom_range(1, 15)));
        run_random(80, 1'b1);

        hold_until_drained();
        repeat (TAIL) @(posedge i_clk);
        if (filter_sb.errors == 0 && filter_sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
